// ===== rtl/gfpar_pkg.sv =====
// Shared types, constants and the GF(2^8) byte multiply for the parity generator.
// No dependencies.
package gfpar_pkg;

   localparam int WORD_W         = 64;
   localparam int BYTE_W         = 8;
   localparam int MAX_LANES      = 8;
   localparam int ROWS_OUT       = 6;
   localparam int COUNT_W        = 3;
   localparam int LANES_DEF      = 8;
   localparam int MAX_ROWS_DEF   = 6;
   localparam int MIN_ROWS       = 2;

   localparam logic [COUNT_W-1:0] PARITY_COUNT_RESET = 3'd2;
   localparam logic [BYTE_W-1:0]  GF_POLY_LOW        = 8'h1B;

   // coefficients of one disk for rows 1 and up
   typedef logic [ROWS_OUT-1:1][BYTE_W-1:0] coef_set_type;

   // all emitted rows of one result
   typedef logic [ROWS_OUT-1:0][WORD_W-1:0] result_type;

   typedef struct packed {
      logic en;
      logic first;
   } lane_ctrl_type;

   typedef struct packed {
      logic               push;
      logic [COUNT_W-1:0] row_count;
   } merge_ctrl_type;

   // GF(2^8) product, reduction x^8+x^4+x^3+x+1
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LOW : '0);
      end
      return acc;
   endfunction

endpackage

// ===== rtl/gfpar_ifs.sv =====
// Valid/ready channel interfaces for the parity generator: request and response.
// Depends on gfpar_pkg.
interface gfpar_req_if import gfpar_pkg::*;;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [BYTE_W-1:0]   coef_row1;
   logic [BYTE_W-1:0]   coef_row2;
   logic [BYTE_W-1:0]   coef_row3;
   logic [BYTE_W-1:0]   coef_row4;
   logic [BYTE_W-1:0]   coef_row5;
   logic                first_disk;
   logic                last_disk;

   modport source(output valid, data_word, coef_row1, coef_row2, coef_row3, coef_row4,
                  coef_row5, first_disk, last_disk, input ready);
   modport sink(input valid, data_word, coef_row1, coef_row2, coef_row3, coef_row4,
                coef_row5, first_disk, last_disk, output ready);
endinterface

interface gfpar_rsp_if import gfpar_pkg::*;;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   parity0;
   logic [WORD_W-1:0]   parity1;
   logic [WORD_W-1:0]   parity2;
   logic [WORD_W-1:0]   parity3;
   logic [WORD_W-1:0]   parity4;
   logic [WORD_W-1:0]   parity5;

   modport source(output valid, parity0, parity1, parity2, parity3, parity4, parity5,
                  input ready);
   modport sink(input valid, parity0, parity1, parity2, parity3, parity4, parity5,
                output ready);
endinterface

// ===== rtl/gfpar_lane.sv =====
// One byte lane: GF(2^8) multiplies and per-row accumulators for that lane.
// Depends on gfpar_pkg.
module gfpar_lane import gfpar_pkg::*; #(
   parameter int ROWS = MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lane_ctrl_type               ctrl,
   input  logic [BYTE_W-1:0]           data_byte,
   input  coef_set_type                coefs,
   output logic [ROWS-1:0][BYTE_W-1:0] acc_next
);

   logic [ROWS-1:0][BYTE_W-1:0] acc_ff;
   logic [ROWS-1:0][BYTE_W-1:0] acc_in;

   // row 0 is plain XOR
   assign acc_in[0] = ctrl.first ? data_byte : (acc_ff[0] ^ data_byte);

   for (genvar r = 1; r < ROWS; r++) begin : g_row
      assign acc_in[r] = ctrl.first ? data_byte : (acc_ff[r] ^ gf_mul(data_byte, coefs[r]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_next = acc_in;

endmodule

// ===== rtl/gfpar_merge.sv =====
// Merge stage: gathers lane accumulators into parity rows, masks inactive rows,
// and holds results in a two-entry output queue. Depends on gfpar_pkg, gfpar_ifs.
module gfpar_merge import gfpar_pkg::*; #(
   parameter int LANES = LANES_DEF,
   parameter int ROWS  = MAX_ROWS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  merge_ctrl_type                         ctrl,
   input  logic [LANES-1:0][ROWS-1:0][BYTE_W-1:0] lane_acc,
   output logic                                   space_ok,
   gfpar_rsp_if.source                            rsp
);

   localparam logic [COUNT_W-1:0] ROWS_CNT = COUNT_W'(ROWS);
   localparam logic [COUNT_W-1:0] MIN_CNT  = COUNT_W'(MIN_ROWS);

   logic [COUNT_W-1:0]  n_eff;
   logic [ROWS_OUT-1:0] row_on;
   result_type          result_in;

   result_type          out_ff;
   logic                out_valid_ff;
   result_type          skid_ff;
   logic                skid_valid_ff;
   logic                pop;

   always_comb begin
      if (ctrl.row_count < MIN_CNT) begin
         n_eff = MIN_CNT;
      end else if (ctrl.row_count > ROWS_CNT) begin
         n_eff = ROWS_CNT;
      end else begin
         n_eff = ctrl.row_count;
      end
      for (int r = 0; r < ROWS_OUT; r++) begin
         row_on[r] = COUNT_W'(r) < n_eff;
      end
   end

   for (genvar r = 0; r < ROWS_OUT; r++) begin : g_row
      for (genvar k = 0; k < MAX_LANES; k++) begin : g_byte
         if (r < ROWS && k < LANES) begin : g_live
            assign result_in[r][BYTE_W*k +: BYTE_W] = row_on[r] ? lane_acc[k][r] : '0;
         end else begin : g_zero
            assign result_in[r][BYTE_W*k +: BYTE_W] = '0;
         end
      end
   end

   assign pop      = out_valid_ff && rsp.ready;
   assign space_ok = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_valid_ff) begin
         if (ctrl.push && pop) begin
            out_ff <= result_in;
         end else if (ctrl.push) begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end else if (ctrl.push) begin
         out_ff       <= result_in;
         out_valid_ff <= 1'b1;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.parity0 = out_ff[0];
   assign rsp.parity1 = out_ff[1];
   assign rsp.parity2 = out_ff[2];
   assign rsp.parity3 = out_ff[3];
   assign rsp.parity4 = out_ff[4];
   assign rsp.parity5 = out_ff[5];

endmodule

// ===== rtl/gf256_multi_parity_generator.sv =====
// RAID stripe parity generator over GF(2^8). One request beat carries one disk's
// 64-bit word and its row coefficients; a beat is taken every clock while ready
// is high. The beat flagged first_disk loads all parity rows, later beats XOR into
// row 0 and add GF products (poly 0x11B) into rows 1 to 5. On the last_disk beat
// a response with all six rows is registered into the output queue; rows at or
// above the clamped parity_count (2 to MAX_PARITY_ROWS) read zero, as do bytes at
// or above BYTE_LANES. Each lane updates its rows combinationally, which sets the
// rate of one beat per clock. A two-entry output queue lets requests keep flowing
// while a response waits; req ready drops only when two responses are held.
// Depends on gfpar_pkg, gfpar_ifs, gfpar_lane, gfpar_merge.
module gf256_multi_parity_generator import gfpar_pkg::*; #(
   parameter int BYTE_LANES      = LANES_DEF,
   parameter int MAX_PARITY_ROWS = MAX_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   gfpar_req_if.sink           req_ch,
   gfpar_rsp_if.source         rsp_ch,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   logic [COUNT_W-1:0]                               count_ff;
   logic                                             accept;
   logic                                             space_ok;
   lane_ctrl_type                                    lane_ctrl;
   merge_ctrl_type                                   merge_ctrl;
   coef_set_type                                     coefs;
   logic [BYTE_LANES-1:0][MAX_PARITY_ROWS-1:0][BYTE_W-1:0] lane_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= PARITY_COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign req_ch.ready = space_ok;
   assign accept       = req_ch.valid && space_ok;

   assign coefs[1] = req_ch.coef_row1;
   assign coefs[2] = req_ch.coef_row2;
   assign coefs[3] = req_ch.coef_row3;
   assign coefs[4] = req_ch.coef_row4;
   assign coefs[5] = req_ch.coef_row5;

   assign lane_ctrl.en     = accept;
   assign lane_ctrl.first  = req_ch.first_disk;
   assign merge_ctrl.push      = accept && req_ch.last_disk;
   assign merge_ctrl.row_count = count_ff;

   for (genvar k = 0; k < BYTE_LANES; k++) begin : g_lane
      gfpar_lane #(
         .ROWS(MAX_PARITY_ROWS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .data_byte (req_ch.data_word[BYTE_W*k +: BYTE_W]),
         .coefs     (coefs),
         .acc_next  (lane_acc[k])
      );
   end

   gfpar_merge #(
      .LANES(BYTE_LANES),
      .ROWS (MAX_PARITY_ROWS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (merge_ctrl),
      .lane_acc (lane_acc),
      .space_ok (space_ok),
      .rsp      (rsp_ch)
   );

endmodule

// ===== rtl/gfpar_checker.sv =====
// Port-level checks for the parity generator, bound to the top level.
// Depends on gfpar_pkg.
module gfpar_checker import gfpar_pkg::*; #(
   parameter int LANES = LANES_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [WORD_W-1:0] req_data_word,
   input logic              req_first,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_parity0
);

   localparam logic [WORD_W-1:0] LANE_MASK = (LANES >= MAX_LANES) ? '1 :
      WORD_W'((65'd1 << (BYTE_W * LANES)) - 65'd1);

   // stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_parity0))
      else $error("response payload changed while stalled");

   // request side backs up only when a response is pending
   a_ready_backs: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !$past(reset))
      else $error("request ready low with no response pending");

   // single-disk stripe into an empty output: row 0 is the masked word
   a_single_disk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_first && req_last && !rsp_valid |=>
         rsp_valid && (rsp_parity0 == ($past(req_data_word) & LANE_MASK)))
      else $error("single-disk stripe gave wrong row 0");

endmodule

bind gf256_multi_parity_generator gfpar_checker #(
   .LANES(BYTE_LANES)
) u_gfpar_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_data_word (req_ch.data_word),
   .req_first     (req_ch.first_disk),
   .req_last      (req_ch.last_disk),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_parity0   (rsp_ch.parity0)
);

// ===== sim/gf256_multi_parity_generator_tb.sv =====
// Testbench for gf256_multi_parity_generator: directed stripes, then random stripes,
// at every parity_count setting. An in-bench GF(2^8) parity predictor checks each beat.
// Depends on gfpar_pkg, gfpar_ifs and the RTL of the block.
module gf256_multi_parity_generator_tb;
   import gfpar_pkg::*;

   localparam int LANES       = LANES_DEF;
   localparam int ROWS_MAX    = MAX_ROWS_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT       = 500000;
   localparam int PHASE_BEATS = 116;
   localparam logic [WORD_W-1:0] LANE_MASK =
      (LANES >= MAX_LANES) ? '1 : ((64'd1 << (BYTE_W * LANES)) - 64'd1);

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      coef_set_type      coefs;
      logic              first;
      logic              last;
   } disk_beat_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   gfpar_req_if req_ch();
   gfpar_rsp_if rsp_ch();

   gf256_multi_parity_generator #(
      .BYTE_LANES      (LANES),
      .MAX_PARITY_ROWS (ROWS_MAX)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   disk_beat_type      pending_beats[$];
   result_type         parity_due[$];
   logic [WORD_W-1:0]  row_acc[ROWS_OUT];
   logic [COUNT_W-1:0] rows_cfg;
   int                 mismatches;
   int                 cycles;
   bit                 burst;

   // stripe shape carried across phases, so count changes land mid-stripe
   int stripe_len;
   int stripe_pos;

   always #5 clock = ~clock;

   function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
      logic [2*BYTE_W-2:0] p;
      p = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) begin
            p = p ^ ((15'(a)) << i);
         end
      end
      for (int j = 2*BYTE_W-2; j >= BYTE_W; j--) begin
         if (p[j]) begin
            p = p ^ (15'h11B << (j - BYTE_W));
         end
      end
      return p[BYTE_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] scale_word(input logic [WORD_W-1:0] w,
                                                    input logic [BYTE_W-1:0] c);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int k = 0; k < MAX_LANES; k++) begin
         r[k*BYTE_W +: BYTE_W] = gf_product(w[k*BYTE_W +: BYTE_W], c);
      end
      return r;
   endfunction

   function automatic void absorb_disk_word(input disk_beat_type b);
      logic [WORD_W-1:0] w;
      result_type        img;
      int                n;
      w = b.data_word & LANE_MASK;
      if (b.first) begin
         for (int r = 0; r < ROWS_OUT; r++) begin
            row_acc[r] = w;
         end
      end else begin
         row_acc[0] = row_acc[0] ^ w;
         for (int r = 1; r < ROWS_OUT; r++) begin
            row_acc[r] = row_acc[r] ^ scale_word(w, b.coefs[r]);
         end
      end
      if (b.last) begin
         n = int'(rows_cfg);
         if (n < MIN_ROWS) begin
            n = MIN_ROWS;
         end
         if (n > ROWS_MAX) begin
            n = ROWS_MAX;
         end
         for (int r = 0; r < ROWS_OUT; r++) begin
            img[r] = (r < n) ? row_acc[r] : '0;
         end
         parity_due.push_back(img);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {MAX_LANES{8'h80}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_beat(input logic [WORD_W-1:0] w, input coef_set_type c,
                             input logic f, input logic l);
      disk_beat_type b;
      b.data_word = w;
      b.coefs     = c;
      b.first     = f;
      b.last      = l;
      pending_beats.push_back(b);
   endtask

   task automatic queue_random_beats(input int count);
      coef_set_type c;
      logic         f;
      logic         l;
      for (int i = 0; i < count; i++) begin
         for (int r = 1; r < ROWS_OUT; r++) begin
            c[r] = pick_coef();
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: arbitrary flags, stripe shape untouched
            f = 1'($urandom_range(0, 1));
            l = 1'($urandom_range(0, 1));
         end else begin
            if (stripe_pos == 0) begin
               stripe_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 6);
            end
            f = (stripe_pos == 0);
            l = (stripe_pos == stripe_len - 1);
            stripe_pos = l ? 0 : stripe_pos + 1;
         end
         queue_beat(pick_word(), c, f, l);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_beats.size() != 0 || req_ch.valid || parity_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_row_count(input logic [COUNT_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      rows_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // request driver
   disk_beat_type on_bus;
   int            send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_disk_word(on_bus);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the beat until taken
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            on_bus = pending_beats.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.data_word  <= on_bus.data_word;
            req_ch.coef_row1  <= on_bus.coefs[1];
            req_ch.coef_row2  <= on_bus.coefs[2];
            req_ch.coef_row3  <= on_bus.coefs[3];
            req_ch.coef_row4  <= on_bus.coefs[4];
            req_ch.coef_row5  <= on_bus.coefs[5];
            req_ch.first_disk <= on_bus.first;
            req_ch.last_disk  <= on_bus.last;
            send_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response monitor and ready generator
   int stall_left;
   int hold_left;
   int rsp_seen;
   bit hold_done;

   always @(posedge clock) begin
      result_type        want;
      logic [WORD_W-1:0] got[ROWS_OUT];
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         rsp_seen   = 0;
         hold_done  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen = rsp_seen + 1;
            got[0] = rsp_ch.parity0;
            got[1] = rsp_ch.parity1;
            got[2] = rsp_ch.parity2;
            got[3] = rsp_ch.parity3;
            got[4] = rsp_ch.parity4;
            got[5] = rsp_ch.parity5;
            if (parity_due.size() == 0) begin
               $error("unexpected parity beat, parity0=%h", got[0]);
               mismatches = mismatches + 1;
            end else begin
               want = parity_due.pop_front();
               for (int r = 0; r < ROWS_OUT; r++) begin
                  if (got[r] !== want[r]) begin
                     $error("parity%0d: expected %h, got %h", r, want[r], got[r]);
                     mismatches = mismatches + 1;
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && rsp_seen == 40) begin
            // long back-pressure: the output queue fills and req ready drops
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (burst) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [COUNT_W-1:0] sweep[8];
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_ch.valid      = 1'b0;
      req_ch.data_word  = '0;
      req_ch.coef_row1  = '0;
      req_ch.coef_row2  = '0;
      req_ch.coef_row3  = '0;
      req_ch.coef_row4  = '0;
      req_ch.coef_row5  = '0;
      req_ch.first_disk = 1'b0;
      req_ch.last_disk  = 1'b0;
      rsp_ch.ready      = 1'b0;
      mismatches        = 0;
      cycles            = 0;
      burst             = 0;
      stripe_len        = 1;
      stripe_pos        = 0;
      rows_cfg          = PARITY_COUNT_RESET;
      for (int r = 0; r < ROWS_OUT; r++) begin
         row_acc[r] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count; no first disk after reset, single-disk stripes, extremes
      queue_beat(64'h0123_4567_89AB_CDEF, {8'h06, 8'h05, 8'h04, 8'h03, 8'h02}, 1'b0, 1'b1);
      queue_beat('1, {5{8'hFF}}, 1'b1, 1'b1);
      queue_beat('0, {5{8'h00}}, 1'b1, 1'b1);
      queue_beat({8{8'h80}}, {5{8'h55}}, 1'b1, 1'b0);
      queue_beat('1, {5{8'hFF}}, 1'b0, 1'b0);
      queue_beat(64'hDEAD_BEEF_0BAD_F00D, {5{8'h00}}, 1'b0, 1'b0);
      queue_beat(64'h8000_0000_0000_0001, {5{8'h01}}, 1'b0, 1'b1);
      queue_beat(64'h0F0F_F0F0_3C3C_C3C3, {8'h80, 8'h02, 8'hCA, 8'h53, 8'h80}, 1'b0, 1'b1);
      wait_drained();

      // all rows, then count changed mid-stripe, below range
      set_row_count(3'd6);
      queue_beat(64'hFEDC_BA98_7654_3210, {5{8'h00}}, 1'b1, 1'b0);
      queue_beat('1, {8'h80, 8'h40, 8'h20, 8'h10, 8'h02}, 1'b0, 1'b0);
      wait_drained();
      set_row_count(3'd0);
      queue_beat(64'h1111_2222_3333_4444, {8'hFF, 8'h53, 8'hCA, 8'h01, 8'h03}, 1'b0, 1'b1);
      queue_beat({8{8'h80}}, {5{8'hFF}}, 1'b1, 1'b1);
      wait_drained();

      // above range
      set_row_count(3'd7);
      queue_beat({8{8'hFF}}, {5{8'hFF}}, 1'b1, 1'b0);
      queue_beat({8{8'h53}}, {5{8'hCA}}, 1'b0, 1'b0);
      queue_beat({8{8'h80}}, {8'h02, 8'h04, 8'h08, 8'h10, 8'h20}, 1'b0, 1'b1);
      queue_beat(64'hA5A5_5A5A_0000_FFFF, {5{8'h01}}, 1'b1, 1'b1);
      wait_drained();

      sweep = '{3'd6, 3'd1, 3'd3, 3'd7, 3'd4, 3'd5, 3'd2, 3'd6};
      for (int p = 0; p < 8; p++) begin
         set_row_count(sweep[p]);
         burst = (p == 2 || p == 5);
         queue_random_beats(PHASE_BEATS);
         wait_drained();
      end
      burst = 0;

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
